FILE: sv/clt_pkg.sv
`timescale 1ns / 1ps
// clt_pkg: shared types and constants of the command-line tokenizer
// used by clt_core and command_line_tokenizer; no dependencies
package clt_pkg;

	localparam int ARG_SLOTS  = 16;
	localparam int LINE_BYTES = 256;

	// tokens_opened stops at ARG_SLOTS-1, bytes_written at LINE_BYTES-1
	localparam int TOK_W = $clog2(ARG_SLOTS);
	localparam int BW_W  = $clog2(LINE_BYTES);

	localparam int RES_MAX   = 3;
	localparam int RES_CNT_W = 2;

	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;

	typedef enum logic [1:0] {
		MODE_GAP   = 2'd0,
		MODE_WORD  = 2'd1,
		MODE_ANGLE = 2'd2,
		MODE_HALT  = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t             mode;
		logic              quote_open;
		logic              start_unwritten;
		logic [TOK_W-1:0]  tokens_opened;
		logic [BW_W-1:0]   bytes_written;
		logic              input_dropped;
	} st_t;

	typedef struct packed {
		logic [7:0] char_in;
		logic       has_char;
		logic       end_of_line;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [3:0] token_index;
		logic       token_start;
		logic       separator;
		logic       line_done;
		logic [3:0] token_count;
		logic       truncated;
		logic       last_of_run;
	} res_t;

	typedef struct packed {
		st_t                       nxt;
		res_t [RES_MAX-1:0]        res;
		logic [RES_CNT_W-1:0]      cnt;
	} step_t;

endpackage

FILE: sv/clt_core.sv
`timescale 1ns / 1ps
// clt_core: combinational step of the tokenizer, one character to up to three results
// depends on clt_pkg
module clt_core (
	input  clt_pkg::st_t   st,
	input  clt_pkg::item_t item,
	output clt_pkg::step_t step
);

	localparam logic [clt_pkg::TOK_W-1:0] TOK_LIMIT  = clt_pkg::TOK_W'(clt_pkg::ARG_SLOTS - 1);
	localparam logic [clt_pkg::BW_W-1:0]  BYTE_LIMIT = clt_pkg::BW_W'(clt_pkg::LINE_BYTES - 1);

	typedef struct packed {
		clt_pkg::st_t  s;
		clt_pkg::res_t r;
	} put_t;

	typedef struct packed {
		clt_pkg::st_t  s;
		logic          v;
		clt_pkg::res_t r;
	} br_t;

	function automatic logic [3:0] to4(input logic [clt_pkg::TOK_W-1:0] v);
		logic [clt_pkg::TOK_W+3:0] w;
		w = {4'b0, v};
		return w[3:0];
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == clt_pkg::CH_SPACE) || (c == clt_pkg::CH_TAB);
	endfunction

	function automatic logic [3:0] cur_idx(input clt_pkg::st_t s);
		logic [clt_pkg::TOK_W-1:0] i;
		i = (s.tokens_opened == '0) ? '0 : s.tokens_opened - 1'b1;
		return to4(i);
	endfunction

	function automatic clt_pkg::res_t mk(input clt_pkg::st_t s, input logic [7:0] b,
		input logic start, input logic sep, input logic done, input logic [3:0] idx);
		clt_pkg::res_t r;
		r.out_byte    = b;
		r.token_index = idx;
		r.token_start = start;
		r.separator   = sep;
		r.line_done   = done;
		r.token_count = to4(s.tokens_opened);
		r.truncated   = s.input_dropped;
		r.last_of_run = 1'b0;
		return r;
	endfunction

	// write a byte or a separator into the line budget
	function automatic put_t put_f(input clt_pkg::st_t s, input logic [7:0] b,
		input logic sep, input logic done);
		put_t p;
		p.r = mk(s, b, s.start_unwritten, sep, done, cur_idx(s));
		p.s = s;
		p.s.start_unwritten = 1'b0;
		p.s.bytes_written   = s.bytes_written + 1'b1;
		if (p.s.bytes_written >= BYTE_LIMIT) begin
			p.s.mode = clt_pkg::MODE_HALT;
		end
		return p;
	endfunction

	function automatic put_t close_f(input clt_pkg::st_t s, input logic done);
		clt_pkg::st_t t;
		t = s;
		t.mode = clt_pkg::MODE_GAP;
		return put_f(t, 8'h00, 1'b1, done);
	endfunction

	function automatic br_t begin_f(input clt_pkg::st_t s, input logic [7:0] c);
		br_t  b;
		put_t p;
		b.s = s;
		b.v = 1'b0;
		b.r = '0;
		if (!is_blank(c)) begin
			if (s.tokens_opened >= TOK_LIMIT) begin
				b.s.input_dropped = 1'b1;
				b.s.mode          = clt_pkg::MODE_HALT;
			end else begin
				b.s.tokens_opened   = s.tokens_opened + 1'b1;
				b.s.quote_open      = 1'b0;
				b.s.start_unwritten = 1'b1;
				if (c == clt_pkg::CH_QUOTE) begin
					b.s.mode       = clt_pkg::MODE_WORD;
					b.s.quote_open = 1'b1;
				end else begin
					b.s.mode = (c == clt_pkg::CH_GT) ? clt_pkg::MODE_ANGLE : clt_pkg::MODE_WORD;
					p   = put_f(b.s, c, 1'b0, 1'b0);
					b.s = p.s;
					b.v = 1'b1;
					b.r = p.r;
				end
			end
		end
		return b;
	endfunction

	clt_pkg::st_t                          s;
	clt_pkg::res_t [clt_pkg::RES_MAX-1:0]  res;
	logic [clt_pkg::RES_CNT_W-1:0]         n;
	put_t                                  p;
	br_t                                   b;
	logic [7:0]                            c;
	logic                                  do_begin;

	always_comb begin
		s        = st;
		res      = '0;
		n        = '0;
		p        = '0;
		b        = '0;
		do_begin = 1'b0;
		c        = item.char_in;

		if (item.has_char && (c != 8'h00)) begin
			case (s.mode)
				clt_pkg::MODE_GAP: begin
					do_begin = 1'b1;
				end
				clt_pkg::MODE_WORD: begin
					if (c == clt_pkg::CH_QUOTE) begin
						s.quote_open = ~s.quote_open;
					end else if (!s.quote_open && is_blank(c)) begin
						p = close_f(s, 1'b0);
						s = p.s;
						res[n] = p.r;
						n = n + 1'b1;
					end else if (!s.quote_open && (c == clt_pkg::CH_GT)) begin
						p = close_f(s, 1'b0);
						s = p.s;
						res[n] = p.r;
						n = n + 1'b1;
						if (s.mode == clt_pkg::MODE_GAP) begin
							do_begin = 1'b1;
						end else begin
							s.input_dropped = 1'b1;
						end
					end else begin
						p = put_f(s, c, 1'b0, 1'b0);
						s = p.s;
						res[n] = p.r;
						n = n + 1'b1;
					end
				end
				clt_pkg::MODE_ANGLE: begin
					if (c == clt_pkg::CH_GT) begin
						// a '>>' token closes right after its second byte
						s.mode = clt_pkg::MODE_GAP;
						p = put_f(s, c, 1'b0, 1'b0);
						s = p.s;
						res[n] = p.r;
						n = n + 1'b1;
						if (s.mode == clt_pkg::MODE_GAP) begin
							p = close_f(s, 1'b0);
							s = p.s;
							res[n] = p.r;
							n = n + 1'b1;
						end
					end else begin
						p = close_f(s, 1'b0);
						s = p.s;
						res[n] = p.r;
						n = n + 1'b1;
						if (s.mode == clt_pkg::MODE_GAP) begin
							do_begin = 1'b1;
						end else if (!is_blank(c)) begin
							s.input_dropped = 1'b1;
						end
					end
				end
				default: begin
					if (!is_blank(c)) begin
						s.input_dropped = 1'b1;
					end
				end
			endcase

			if (do_begin) begin
				b = begin_f(s, c);
				s = b.s;
				if (b.v) begin
					res[n] = b.r;
					n = n + 1'b1;
				end
			end
		end

		if (item.end_of_line) begin
			if ((s.mode == clt_pkg::MODE_WORD) || (s.mode == clt_pkg::MODE_ANGLE)) begin
				p = close_f(s, 1'b1);
				res[n] = p.r;
			end else begin
				res[n] = mk(s, 8'h00, 1'b0, 1'b0, 1'b1, 4'd0);
			end
			n = n + 1'b1;
			s = '0;
		end

		if (n != '0) begin
			res[n - 1'b1].last_of_run = 1'b1;
		end

		step.nxt = s;
		step.res = res;
		step.cnt = n;
	end

endmodule

FILE: sv/command_line_tokenizer.sv
`timescale 1ns / 1ps
// command_line_tokenizer: streaming tokenizer top level, input stage, state and result buffer
// depends on clt_pkg and clt_core
//
// One line character enters per request on the slave side; the tokens leave byte by byte on the
// master side, each closed by a separator request unless the byte budget runs out, and an
// end-of-line request closes the line with a done request that carries the token count. A
// character is held in the input stage and its results go in one pass into a three-entry result
// buffer, so a new character is accepted every cycle as long as each causes at most one result
// and the master side is ready. The master side moves one result per cycle while m_tready is
// high; a character that causes k results (k up to three) holds the next one back until its last
// result is taken. Output stalls never drop or repeat a result.
module command_line_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // char_in[7:0]
	input  logic [0:0]  s_tuser,   // has_char[0]
	input  logic        s_tlast,   // end_of_line
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // out_byte[7:0], token_index[11:8], token_count[15:12],
	                               // truncated[16], zero[23:17]
	output logic [2:0]  m_tuser,   // token_start[0], separator[1], line_done[2]
	output logic        m_tlast    // last_of_run
);

	clt_pkg::item_t                        item_s1;
	logic                                  valid_s1;
	clt_pkg::st_t                          state_q;
	clt_pkg::res_t [clt_pkg::RES_MAX-1:0]  res_q;
	logic [clt_pkg::RES_CNT_W-1:0]         cnt_q;
	logic [clt_pkg::RES_CNT_W-1:0]         ptr_q;
	clt_pkg::step_t                        step;
	clt_pkg::res_t                         cur;
	logic                                  fire;
	logic                                  out_take;

	clt_core u_core (
		.st   (state_q),
		.item (item_s1),
		.step (step)
	);

	assign m_tvalid = (cnt_q != '0);
	assign out_take = m_tvalid && m_tready;
	// the buffered item commits once the result buffer is empty or about to be
	assign fire     = valid_s1 && ((cnt_q == '0) || ((cnt_q == 2'd1) && m_tready));
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.char_in     <= s_tdata;
			item_s1.has_char    <= s_tuser[0];
			item_s1.end_of_line <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			cnt_q   <= '0;
			ptr_q   <= '0;
		end else if (fire) begin
			state_q <= step.nxt;
			cnt_q   <= step.cnt;
			ptr_q   <= '0;
		end else if (out_take) begin
			cnt_q <= cnt_q - 1'b1;
			ptr_q <= ptr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= step.res;
		end
	end

	assign cur     = res_q[ptr_q];
	assign m_tdata = {7'b0, cur.truncated, cur.token_count, cur.token_index, cur.out_byte};
	assign m_tuser = {cur.line_done, cur.separator, cur.token_start};
	assign m_tlast = cur.last_of_run;

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (m_tvalid == ($past(step.cnt) != '0)))
		else $error("result buffer load does not match result count");

	a_last_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (cnt_q == 2'd1)))
		else $error("tlast not on the final buffered result");

	a_line_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && item_s1.end_of_line) |=>
		((state_q.mode == clt_pkg::MODE_GAP) && (state_q.tokens_opened == '0) &&
		 (state_q.bytes_written == '0) && !state_q.input_dropped))
		else $error("state not cleared after end of line");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (cnt_q > 2'd1)) |-> !s_tready)
		else $error("input taken while result buffer still busy");

endmodule
